// File: rtl/dsrc_pkg.sv
// Shared types and constants for the datagram sequence and reassembly check unit.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package dsrc_pkg;

    // Reassembly buffer size in bytes. The usable limit saturates at 32767 so that
    // the running byte count always fits in 15 bits.
    localparam int unsigned REASSEMBLY_BYTES = 16384;
    localparam int unsigned BUF_LIMIT_INT    =
        (REASSEMBLY_BYTES > 32767) ? 32767 : REASSEMBLY_BYTES;
    localparam logic [14:0] BUF_LIMIT        = 15'(BUF_LIMIT_INT);

    localparam int unsigned SEQ_W   = 31;
    localparam int unsigned LEN_W   = 15;
    localparam int unsigned AVAIL_W = 11;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FULL_FRAG_LEN     = 2'd0;
    localparam logic [1:0] CFG_MAX_MESSAGE_BYTES = 2'd1;
    localparam logic [1:0] CFG_ACK_FRAGMENTS     = 2'd2;

    localparam logic [14:0] RST_FULL_FRAG_LEN     = 15'd1300;
    localparam logic [15:0] RST_MAX_MESSAGE_BYTES = 16'd16384;
    localparam logic        RST_ACK_FRAGMENTS     = 1'b1;

    typedef enum logic [2:0] {
        VERDICT_WHOLE       = 3'd0,
        VERDICT_REASSEMBLED = 3'd1,
        VERDICT_STALE       = 3'd2,
        VERDICT_HELD        = 3'd3,
        VERDICT_GAP         = 3'd4,
        VERDICT_BAD_LENGTH  = 3'd5,
        VERDICT_TOO_LONG    = 3'd6
    } t_verdict;

    typedef struct packed {
        logic [14:0] full_frag_len;
        logic [15:0] max_message_bytes;
        logic        ack_fragments;
    } t_cfg;

    typedef struct packed {
        logic [SEQ_W-1:0] last_seq;
        logic [SEQ_W-1:0] build_seq;
        logic [LEN_W-1:0] assembled;
    } t_state;

    typedef struct packed {
        logic [SEQ_W-1:0]   seq_number;
        logic               is_fragment;
        logic [15:0]        frag_start;
        logic [15:0]        frag_len;
        logic [AVAIL_W-1:0] bytes_available;
    } t_header;

    typedef struct packed {
        t_verdict         verdict;
        logic [SEQ_W-1:0] dropped_count;
        logic [LEN_W-1:0] store_offset;
        logic [LEN_W-1:0] message_bytes;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/dsrc_cfg_regs.sv
// Configuration registers of the datagram sequence and reassembly check unit.
// Depends on dsrc_pkg for register indexes, reset values and the t_cfg struct.
`default_nettype none

module dsrc_cfg_regs (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr_en,
    input  wire logic [1:0]    i_wr_index,
    input  wire logic [15:0]   i_wr_data,
    output dsrc_pkg::t_cfg     o_cfg
);

    dsrc_pkg::t_cfg r_cfg;
    dsrc_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            case (i_wr_index)
                dsrc_pkg::CFG_FULL_FRAG_LEN:     n_cfg.full_frag_len     = i_wr_data[14:0];
                dsrc_pkg::CFG_MAX_MESSAGE_BYTES: n_cfg.max_message_bytes = i_wr_data;
                dsrc_pkg::CFG_ACK_FRAGMENTS:     n_cfg.ack_fragments     = i_wr_data[0];
                default:                         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.full_frag_len     <= dsrc_pkg::RST_FULL_FRAG_LEN;
            r_cfg.max_message_bytes <= dsrc_pkg::RST_MAX_MESSAGE_BYTES;
            r_cfg.ack_fragments     <= dsrc_pkg::RST_ACK_FRAGMENTS;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: rtl/dsrc_decide.sv
// Per-header decision logic: sequence check, fragment order and length checks,
// and the next sequence and reassembly state. Depends on dsrc_pkg.
`default_nettype none

module dsrc_decide (
    input  wire dsrc_pkg::t_header i_hdr,
    input  wire dsrc_pkg::t_state  i_state,
    input  wire dsrc_pkg::t_cfg    i_cfg,
    output dsrc_pkg::t_result      o_result,
    output dsrc_pkg::t_state       o_state
);

    logic        stale;
    logic        new_build;
    logic [14:0] cur_asm;
    logic        start_ok;
    logic        len_bad;
    logic [15:0] sum;
    logic [14:0] new_asm;

    assign stale     = (i_hdr.seq_number <= i_state.last_seq);
    assign new_build = (i_hdr.seq_number != i_state.build_seq);
    assign cur_asm   = new_build ? '0 : i_state.assembled;

    // The start offset is signed; a negative one never matches the byte count.
    assign start_ok = !i_hdr.frag_start[15] && (i_hdr.frag_start[14:0] == cur_asm);

    assign sum     = {1'b0, cur_asm} + {1'b0, i_hdr.frag_len[14:0]};
    assign new_asm = sum[14:0];
    assign len_bad = i_hdr.frag_len[15]
                  || (i_hdr.frag_len[14:0] > {4'b0, i_hdr.bytes_available})
                  || (sum > {1'b0, dsrc_pkg::BUF_LIMIT});

    always_comb begin
        o_state                = i_state;
        o_result.verdict       = dsrc_pkg::VERDICT_STALE;
        o_result.dropped_count = '0;
        o_result.store_offset  = '0;
        o_result.message_bytes = '0;
        if (!stale) begin
            o_result.dropped_count = i_hdr.seq_number - i_state.last_seq - 31'd1;
            if (!i_hdr.is_fragment) begin
                o_result.verdict = dsrc_pkg::VERDICT_WHOLE;
                o_state.last_seq = i_hdr.seq_number;
            end else begin
                o_state.build_seq = i_hdr.seq_number;
                o_state.assembled = cur_asm;
                if (!start_ok) begin
                    o_result.verdict = dsrc_pkg::VERDICT_GAP;
                end else if (len_bad) begin
                    o_result.verdict = dsrc_pkg::VERDICT_BAD_LENGTH;
                end else begin
                    o_result.store_offset = cur_asm;
                    o_state.assembled     = new_asm;
                    if (i_hdr.frag_len[14:0] == i_cfg.full_frag_len) begin
                        o_result.verdict = dsrc_pkg::VERDICT_HELD;
                    end else if ({1'b0, new_asm} > i_cfg.max_message_bytes) begin
                        o_result.verdict = dsrc_pkg::VERDICT_TOO_LONG;
                    end else begin
                        o_result.verdict       = dsrc_pkg::VERDICT_REASSEMBLED;
                        o_result.message_bytes = new_asm;
                        o_state.assembled      = '0;
                        if (i_cfg.ack_fragments) begin
                            o_state.last_seq = i_hdr.seq_number;
                        end
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/datagram_sequence_reassembly_check_unit.sv
// Top level of the datagram sequence and reassembly check unit: input register,
// sequence state, result register. Depends on dsrc_pkg, dsrc_cfg_regs, dsrc_decide.
`default_nettype none

// One received-datagram header goes in per word and one verdict word comes out
// per header, in order. The block takes a header every clock cycle unless both
// registers are full and the sink stalls; a header passes from the input register
// through the decision logic into the output register, which then presents
// its result on the output. The
// sequence and reassembly state is updated in the same cycle as the decision,
// so each header sees the effect of the one before it. The output register
// holds a result while the sink stalls and the input side keeps accepting until
// both registers are full. Configuration writes are accepted at any time and
// should be issued only while no header is in flight.
module datagram_sequence_reassembly_check_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [30:0] seq_number, [46:31] frag_start, [62:47] frag_len,
    // [73:63] bytes_available, [79:74] zero
    input  wire logic [79:0] i_s_axis_tdata,
    // [0] is_fragment
    input  wire logic        i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [30:0] dropped_count, [45:31] store_offset, [60:46] message_bytes, [63:61] zero
    output logic [63:0]      o_m_axis_tdata,
    // [2:0] verdict
    output logic [2:0]       o_m_axis_tuser,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    dsrc_pkg::t_cfg    cfg;
    dsrc_pkg::t_header r_hdr;
    logic              r_hdr_valid;
    dsrc_pkg::t_state  r_state;
    dsrc_pkg::t_state  n_state;
    dsrc_pkg::t_result n_result;
    dsrc_pkg::t_result r_result;
    logic              r_out_valid;
    logic              fire;
    logic              in_take;

    assign o_cfg_ready = 1'b1;

    dsrc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    dsrc_decide u_decide (
        .i_hdr    (r_hdr),
        .i_state  (r_state),
        .i_cfg    (cfg),
        .o_result (n_result),
        .o_state  (n_state)
    );

    // The registered header is decided when the output register is free or drains.
    assign fire            = r_hdr_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_hdr_valid || fire;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (in_take) begin
                r_hdr_valid <= 1'b1;
            end else if (fire) begin
                r_hdr_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_hdr.seq_number      <= i_s_axis_tdata[30:0];
            r_hdr.is_fragment     <= i_s_axis_tuser;
            r_hdr.frag_start      <= i_s_axis_tdata[46:31];
            r_hdr.frag_len        <= i_s_axis_tdata[62:47];
            r_hdr.bytes_available <= i_s_axis_tdata[73:63];
        end
        if (fire) begin
            r_result <= n_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_result.verdict;
    assign o_m_axis_tdata  = {3'b000, r_result.message_bytes, r_result.store_offset,
                              r_result.dropped_count};

    // The last accepted sequence never moves backward outside of reset.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_state.last_seq >= $past(r_state.last_seq)))
        else $error("last accepted sequence decreased");

    // The running byte count stays within the reassembly buffer.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.assembled <= dsrc_pkg::BUF_LIMIT)
        else $error("assembled byte count beyond buffer limit");

    // A store offset is reported only for accepted fragment payload.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_result.store_offset != '0)) |->
        ((r_result.verdict == dsrc_pkg::VERDICT_REASSEMBLED)
         || (r_result.verdict == dsrc_pkg::VERDICT_HELD)
         || (r_result.verdict == dsrc_pkg::VERDICT_TOO_LONG)))
        else $error("store offset on a verdict without payload");

    // A message length is reported only on a reassembled delivery.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_result.message_bytes != '0)) |->
        (r_result.verdict == dsrc_pkg::VERDICT_REASSEMBLED))
        else $error("message length without reassembled delivery");

endmodule

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for datagram_sequence_reassembly_check_unit: a stream driver and
// a monitor around the block, checked word by word against a header-by-header predictor.
// Depends on dsrc_pkg and the block's RTL.
module tb_top;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 6;
    localparam int PHASE_ITEMS  = 260;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 400;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [79:0] i_s_axis_tdata  = '0;
    logic        i_s_axis_tuser  = 1'b0;
    logic        i_m_axis_tready = 1'b0;
    logic        i_cfg_valid     = 1'b0;
    logic [1:0]  i_cfg_index     = dsrc_pkg::CFG_FULL_FRAG_LEN;
    logic [15:0] i_cfg_data      = '0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [63:0] o_m_axis_tdata;
    logic [2:0]  o_m_axis_tuser;
    logic        o_cfg_ready;

    datagram_sequence_reassembly_check_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // Shadow of the block's sequence state and registers.
    logic [dsrc_pkg::SEQ_W-1:0] acc_seq       = '0;
    logic [dsrc_pkg::SEQ_W-1:0] open_seq      = '0;
    logic [dsrc_pkg::LEN_W-1:0] built_bytes   = '0;
    logic [14:0]                frag_size_reg = dsrc_pkg::RST_FULL_FRAG_LEN;
    logic [15:0]                msg_limit_reg = dsrc_pkg::RST_MAX_MESSAGE_BYTES;
    logic                       ack_reg       = dsrc_pkg::RST_ACK_FRAGMENTS;

    dsrc_pkg::t_header hdr_pending[$];
    dsrc_pkg::t_result verdicts_due[$];
    dsrc_pkg::t_header drv_hdr        = '0;
    int                send_idle_pct  = 0;
    int                recv_stall_pct = 0;
    bit                hold_req       = 1'b0;
    bit                hold_done      = 1'b0;
    int                hold_left      = 0;
    int                fail_count     = 0;
    int unsigned       gen_next       = 0;
    int                gen_items      = 0;

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic dsrc_pkg::t_result judge_header(dsrc_pkg::t_header h);
        dsrc_pkg::t_result r;
        int                start;
        int                flen;
        r     = '0;
        start = int'($signed(h.frag_start));
        flen  = int'($signed(h.frag_len));
        if (h.seq_number <= acc_seq) begin
            r.verdict = dsrc_pkg::VERDICT_STALE;
        end else begin
            r.dropped_count = h.seq_number - acc_seq - 1'b1;
            if (!h.is_fragment) begin
                r.verdict = dsrc_pkg::VERDICT_WHOLE;
                acc_seq   = h.seq_number;
            end else begin
                // A new sequence always restarts the message before the fragment checks.
                if (h.seq_number != open_seq) begin
                    open_seq    = h.seq_number;
                    built_bytes = '0;
                end
                if (start != int'(built_bytes)) begin
                    r.verdict = dsrc_pkg::VERDICT_GAP;
                end else if (flen < 0 || flen > int'(h.bytes_available) ||
                             int'(built_bytes) + flen > int'(dsrc_pkg::BUF_LIMIT_INT)) begin
                    r.verdict = dsrc_pkg::VERDICT_BAD_LENGTH;
                end else begin
                    r.store_offset = built_bytes;
                    built_bytes    = built_bytes + dsrc_pkg::LEN_W'(flen);
                    if (flen == int'(frag_size_reg)) begin
                        r.verdict = dsrc_pkg::VERDICT_HELD;
                    end else if (int'(built_bytes) > int'(msg_limit_reg)) begin
                        r.verdict = dsrc_pkg::VERDICT_TOO_LONG;
                    end else begin
                        r.verdict       = dsrc_pkg::VERDICT_REASSEMBLED;
                        r.message_bytes = built_bytes;
                        built_bytes     = '0;
                        if (ack_reg) acc_seq = h.seq_number;
                    end
                end
            end
        end
        return r;
    endfunction

    // Header driver: a word stays on the bus until it is taken.
    always @(posedge i_clk) begin
        logic give;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            give = i_s_axis_tvalid && !o_s_axis_tready;
            if (i_s_axis_tvalid && o_s_axis_tready) verdicts_due.push_back(judge_header(drv_hdr));
            if (!give && hdr_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                drv_hdr = hdr_pending.pop_front();
                give    = 1'b1;
            end
            i_s_axis_tvalid <= give;
            i_s_axis_tdata  <= {6'd0, drv_hdr.bytes_available, drv_hdr.frag_len,
                                drv_hdr.frag_start, drv_hdr.seq_number};
            i_s_axis_tuser  <= drv_hdr.is_fragment;
        end
    end

    // Result sink with random stalls and one long hold-off.
    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        dsrc_pkg::t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (verdicts_due.size() == 0) begin
                $error("result word with no header pending, verdict %0d", o_m_axis_tuser);
                fail_count++;
            end else begin
                want = verdicts_due.pop_front();
                check_field("verdict", want.verdict, o_m_axis_tuser);
                check_field("dropped_count", want.dropped_count, o_m_axis_tdata[30:0]);
                check_field("store_offset", want.store_offset, o_m_axis_tdata[45:31]);
                check_field("message_bytes", want.message_bytes, o_m_axis_tdata[60:46]);
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            dsrc_pkg::CFG_FULL_FRAG_LEN:     frag_size_reg = val[14:0];
            dsrc_pkg::CFG_MAX_MESSAGE_BYTES: msg_limit_reg = val;
            dsrc_pkg::CFG_ACK_FRAGMENTS:     ack_reg = val[0];
            default: ;
        endcase
    endtask

    // Sampled at the falling edge so the driver's updates of the same cycle are seen.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (hdr_pending.size() != 0 || i_s_axis_tvalid || verdicts_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_hdr(int unsigned seq, bit frag, int start, int len, int avail);
        dsrc_pkg::t_header h;
        h.seq_number      = dsrc_pkg::SEQ_W'(seq);
        h.is_fragment     = frag;
        h.frag_start      = 16'(start);
        h.frag_len        = 16'(len);
        h.bytes_available = dsrc_pkg::AVAIL_W'(avail);
        hdr_pending.push_back(h);
        gen_items++;
    endtask

    // Mostly the next sequence number, sometimes after a few or many skipped ones.
    function automatic int unsigned fresh_seq();
        int unsigned pick;
        case ($urandom_range(0, 9))
            0:       pick = gen_next + $urandom_range(1, 4);
            1:       pick = gen_next + $urandom_range(5, 1 << 16);
            default: pick = gen_next;
        endcase
        gen_next = pick + 1;
        return pick;
    endfunction

    task automatic queue_bad_frag(int unsigned seq, int start);
        int len;
        case ($urandom_range(0, 2))
            0: queue_hdr(seq, 1'b1, start ^ (1 << $urandom_range(0, 15)), 1, 1);
            1: queue_hdr(seq, 1'b1, start, -int'($urandom_range(1, 32768)), $urandom);
            default: begin
                len = $urandom_range(1, 2047);
                queue_hdr(seq, 1'b1, start, len, $urandom_range(0, len - 1));
            end
        endcase
    endtask

    task automatic queue_message();
        int unsigned seq;
        int          fs;
        int          nfull;
        int          start;
        int          len;
        fs    = int'(frag_size_reg);
        seq   = fresh_seq();
        start = 0;
        if (fs > 2047) begin
            nfull = 0;
        end else if (fs > 0 && $urandom_range(0, 7) == 0) begin
            // As many full fragments as fit in the reassembly buffer, but at most 24.
            nfull = int'(dsrc_pkg::BUF_LIMIT_INT) / fs;
            if (nfull > 24) nfull = 24;
        end else begin
            nfull = $urandom_range(0, 5);
        end
        for (int i = 0; i < nfull; i++) begin
            if ($urandom_range(0, 19) == 0) queue_bad_frag(seq, start);
            queue_hdr(seq, 1'b1, start, fs, fs + $urandom_range(0, 2047 - fs) * $urandom_range(0, 1));
            start += fs;
        end
        if ($urandom_range(0, 7) == 0) return;
        if (fs == 0 || $urandom_range(0, 3) == 0) len = $urandom_range(0, 2047);
        else len = $urandom_range(0, (fs > 2048) ? 2047 : fs - 1);
        if (len == fs) len = (fs == 0) ? 1 : fs - 1;
        queue_hdr(seq, 1'b1, start, len, len + $urandom_range(0, 2047 - len) * $urandom_range(0, 1));
    endtask

    task automatic queue_random_unit();
        case ($urandom_range(0, 9))
            0, 1: queue_hdr(fresh_seq(), 1'b0, $urandom, $urandom, $urandom);
            2: begin
                // Late or repeated sequence number.
                queue_hdr($urandom_range(0, gen_next - 1), $urandom_range(0, 1),
                          $urandom, $urandom, $urandom);
            end
            3: queue_hdr(fresh_seq(), $urandom_range(0, 1), $urandom, $urandom, $urandom);
            default: queue_message();
        endcase
    endtask

    task automatic run_phase(int fs, int limit, bit ack, int idle_s, int idle_r,
                             int unsigned seq_floor);
        write_reg(dsrc_pkg::CFG_FULL_FRAG_LEN, 16'(fs));
        write_reg(dsrc_pkg::CFG_MAX_MESSAGE_BYTES, 16'(limit));
        write_reg(dsrc_pkg::CFG_ACK_FRAGMENTS, 16'(ack));
        send_idle_pct  = idle_s;
        recv_stall_pct = idle_r;
        if (gen_next < seq_floor) gen_next = seq_floor;
        gen_items = 0;
        while (gen_items < PHASE_ITEMS) queue_random_unit();
        wait_drained();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed headers under the reset configuration.
        queue_hdr(1, 1'b0, 0, 0, 0);
        queue_hdr(1, 1'b0, 16'h7FFF, 16'h7FFF, 2047);
        queue_hdr(0, 1'b1, 0, 5, 5);
        queue_hdr(5, 1'b0, 16'h8000, 16'h8000, 0);
        queue_hdr(6, 1'b1, 16'h8000, 0, 0);
        queue_hdr(6, 1'b1, 0, 1300, 1300);
        queue_hdr(6, 1'b1, 0, 10, 10);
        queue_hdr(6, 1'b1, 1300, -1, 2047);
        queue_hdr(6, 1'b1, 1300, 200, 199);
        queue_hdr(6, 1'b1, 1300, 1300, 2047);
        queue_hdr(6, 1'b1, 2600, 2047, 2047);
        queue_hdr(6, 1'b1, 0, 1, 1);
        queue_hdr(8, 1'b1, 0, 0, 0);
        queue_hdr(9, 1'b1, 0, 16'h7FFF, 2047);
        gen_next = 10;
        wait_drained();

        // The sink holds off at the start of the first phase so the block backs up.
        hold_req = 1'b1;
        run_phase(1300, 16384, 1'b1, 0, 0, 0);
        run_phase(0, 65535, 1'b0, 53, 0, (1 << 20) + $urandom_range(0, (1 << 20) - 1));
        run_phase(32767, 0, 1'b1, 0, 53, (1 << 27) + $urandom_range(0, (1 << 27) - 1));
        run_phase(700, 3000, 1'b1, 23, 23, (1 << 29) + $urandom_range(0, (1 << 28) - 1));
        run_phase(1, 2, 1'b0, 23, 23, (1 << 30) + $urandom_range(0, (1 << 29) - 1));

        // Top of the sequence space; everything after it is stale.
        queue_hdr(32'h7FFF_FFFF, 1'b0, 0, 0, 0);
        queue_hdr(32'h7FFF_FFFF, 1'b1, 0, 10, 10);
        queue_hdr(32'h7FFF_FFFF, 1'b0, 16'hFFFF, 16'hFFFF, 2047);
        wait_drained();

        if (fail_count == 0 && verdicts_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/dsrc_pkg.sv
rtl/dsrc_cfg_regs.sv
rtl/dsrc_decide.sv
rtl/datagram_sequence_reassembly_check_unit.sv
dv/tb_top.sv
